// ===== src/scba_pkg.sv =====
// Package for the size-class block allocator: request/command types,
// class size table and width constants. No dependencies.
`default_nettype none
package scba_pkg;

    localparam int unsigned ADDR_W  = 19;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned CLS_W   = 6;
    localparam int unsigned FREE_W  = 17;
    localparam int unsigned LINK_AW = 17;
    localparam int unsigned TBL_N   = 64;
    localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERSIZE = 2'd1,
        ST_NO_PAGES = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_POP  = 2'd2
    } t_bk_state;

    // classified request handed from front to back
    typedef struct packed {
        t_func             func;
        logic              oversize;
        logic [CLS_W-1:0]  cls;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] grant_addr;
        logic [CLS_W-1:0]  size_class;
        logic [FREE_W-1:0] class_free_blocks;
    } t_rsp;

    function automatic logic [11:0] class_bytes(input logic [CLS_W-1:0] c);
        logic [11:0] r;
        if (c < 6'd24)      r = 12'(({6'd0, c} + 12'd1) << 2);
        else if (c < 6'd41) r = 12'(12'd96 + ({6'd0, c} - 12'd23) * 12'd32);
        else                r = 12'(12'd640 + ({6'd0, c} - 12'd40) * 12'd64);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/scba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module scba_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 131072
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/scba_front.sv =====
// Front end: accepts requests, maps size to class, queues classified commands.
// Depends on scba_pkg.
`default_nettype none
module scba_front #(
    parameter int unsigned NUM_CLASSES = 47
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [0:0]            i_func,
    input  wire [31:0]           i_size,
    input  wire [18:0]           i_addr,
    output logic                 o_cmd_valid,
    input  wire                  i_cmd_ready,
    output scba_pkg::t_cmd       o_cmd
);
    scba_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    scba_pkg::t_cmd w_cmd;
    logic w_push, w_pop;

    // priority search over the constant class table
    always_comb begin
        w_cmd.func     = scba_pkg::t_func'(i_func);
        w_cmd.addr     = i_addr;
        w_cmd.oversize = 1'b1;
        w_cmd.cls      = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (i < scba_pkg::TBL_N &&
                {20'd0, scba_pkg::class_bytes(scba_pkg::CLS_W'(i))} >= i_size) begin
                w_cmd.oversize = 1'b0;
                w_cmd.cls      = scba_pkg::CLS_W'(i);
            end
        end
        if (w_cmd.oversize) w_cmd.cls = '0;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule
`default_nettype wire

// ===== src/scba_back.sv =====
// Back end: free lists, page carving, pool page counter and link memory.
// Depends on scba_pkg and scba_ram.
`default_nettype none
module scba_back #(
    parameter int unsigned NUM_PAGES       = 64,
    parameter int unsigned PAGE_BYTES      = 8192,
    parameter int unsigned NUM_CLASSES     = 47,
    parameter int unsigned HEADER_BYTES    = 8,
    parameter int unsigned ALIGN_BYTES     = 4,
    parameter int unsigned MIN_BLOCK_BYTES = 8
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cmd_valid,
    output logic            o_cmd_ready,
    input  scba_pkg::t_cmd  i_cmd,
    output logic            o_rsp_valid,
    input  wire             i_rsp_ready,
    output scba_pkg::t_rsp  o_rsp
);
    localparam int unsigned PG_W   = $clog2(NUM_PAGES + 1);
    localparam int unsigned BODY   = PAGE_BYTES - HEADER_BYTES;
    localparam int unsigned IDX_W  = $clog2(BODY / 4 + 2);
    localparam int unsigned AW     = scba_pkg::ADDR_W;
    localparam int unsigned FW     = scba_pkg::FREE_W;
    localparam int unsigned CLS_AW = $clog2(NUM_CLASSES);

    // per-class state word, held in a RAM and read back in the cycle after accept
    typedef struct packed {
        logic             head_v;
        logic [AW-1:0]    head;
        logic             cvalid;
        logic [PG_W-1:0]  cpage;
        logic [IDX_W-1:0] cidx;
        logic [FW-1:0]    free;
    } t_cls_word;
    localparam int unsigned CW_W = $bits(t_cls_word);

    logic [NUM_CLASSES-1:0] r_cls_ok;   // class word written since reset
    logic [PG_W-1:0]        r_next_page;
    t_cls_word              r_word, n_word;

    scba_pkg::t_bk_state r_st, n_st;
    scba_pkg::t_cmd      r_cmd;
    logic                r_ovalid;
    scba_pkg::t_rsp      r_rsp, n_rsp;

    logic [12:0]       w_bb;
    logic [IDX_W-1:0]  w_bpp;
    logic [5:0]        w_c;
    t_cls_word         w_cls_rd, w_cur, w_cls_wdata;
    logic              w_cls_we;
    logic [CLS_AW-1:0] w_cls_waddr, w_cls_raddr;
    logic [AW:0]       w_link_rd;
    logic              w_we;
    logic [scba_pkg::LINK_AW-1:0] w_waddr, w_raddr;
    logic [AW:0]       w_wdata;
    logic              w_carve_new, w_nopage, w_carve_take;
    logic [FW:0]       w_fadd;
    logic [31:0]       w_gaddr;
    logic [PG_W-1:0]   w_pg;
    logic [IDX_W-1:0]  w_ix;

    assign w_c = r_cmd.cls;

    // block bytes and blocks per page as constant tables per class
    logic [12:0]      c_bb  [NUM_CLASSES];
    logic [IDX_W-1:0] c_bpp [NUM_CLASSES];
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_bpp
        localparam int unsigned SB0 = (g < 24) ? 4 * (g + 1) :
                                      (g < 41) ? 96 + (g - 23) * 32 :
                                      (g < 64) ? 640 + (g - 40) * 64 : 4096;
        localparam int unsigned SB1 = (SB0 < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : SB0;
        localparam int unsigned SB  = (SB1 + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
        assign c_bb[g]  = 13'(SB);
        assign c_bpp[g] = IDX_W'(BODY / SB);
    end

    assign w_bb  = c_bb[w_c];
    assign w_bpp = c_bpp[w_c];

    scba_ram #(.WIDTH(CW_W), .DEPTH(NUM_CLASSES)) u_cls (
        .i_clk  (i_clk),
        .i_we   (w_cls_we),
        .i_waddr(w_cls_waddr),
        .i_wdata(w_cls_wdata),
        .i_raddr(w_cls_raddr),
        .o_rdata(w_cls_rd)
    );

    scba_ram #(.WIDTH(AW + 1), .DEPTH(2 ** scba_pkg::LINK_AW)) u_link (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_link_rd)
    );

    assign w_cls_raddr = CLS_AW'(i_cmd.cls);
    assign w_cls_waddr = CLS_AW'(w_c);
    assign w_cur       = r_cls_ok[w_c] ? w_cls_rd : '0;

    assign w_waddr = r_cmd.addr[AW-1:2];
    assign w_wdata = {w_cur.head_v, w_cur.head};
    assign w_raddr = w_cur.head[AW-1:2];
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_rsp;
    assign o_cmd_ready = (r_st == scba_pkg::BK_IDLE) && (!r_ovalid || i_rsp_ready);

    always_comb begin
        w_carve_new = !w_cur.cvalid || (w_cur.cidx >= w_bpp);
        w_nopage    = w_carve_new && (w_bpp == '0 || r_next_page >= PG_W'(NUM_PAGES));
        w_pg        = w_carve_new ? r_next_page : w_cur.cpage;
        w_ix        = w_carve_new ? '0 : w_cur.cidx;
        w_fadd      = {1'b0, w_cur.free} + (w_carve_new ? (FW+1)'(w_bpp) : '0);
        if (w_fadd > {1'b0, scba_pkg::FREE_MAX}) w_fadd = {1'b0, scba_pkg::FREE_MAX};
        w_gaddr     = 32'(w_pg) * 32'(PAGE_BYTES) + 32'(HEADER_BYTES)
                    + 32'(w_ix) * 32'(w_bb);
    end

    always_comb begin
        n_st         = r_st;
        n_rsp        = r_rsp;
        n_word       = w_cur;
        w_we         = 1'b0;
        w_cls_we     = 1'b0;
        w_carve_take = 1'b0;
        n_rsp.status     = scba_pkg::ST_DONE;
        n_rsp.grant_addr = '0;
        n_rsp.size_class = w_c;
        unique case (r_st)
            scba_pkg::BK_IDLE: if (i_cmd_valid && o_cmd_ready) n_st = scba_pkg::BK_READ;
            scba_pkg::BK_READ: begin
                n_st = scba_pkg::BK_IDLE;
                if (r_cmd.oversize) begin
                    n_rsp.status = scba_pkg::ST_OVERSIZE;
                    n_rsp.size_class = '0;
                    n_rsp.class_free_blocks = '0;
                end else if (r_cmd.func == scba_pkg::FN_FREE) begin
                    w_we     = 1'b1;
                    w_cls_we = 1'b1;
                    n_word.head   = r_cmd.addr;
                    n_word.head_v = 1'b1;
                    n_word.free   = (w_cur.free == scba_pkg::FREE_MAX) ?
                        w_cur.free : FW'(w_cur.free + 1'b1);
                    n_rsp.class_free_blocks = n_word.free;
                end else if (w_cur.head_v) begin
                    // head is rewritten next cycle once the link word is back
                    n_st = scba_pkg::BK_POP;
                    n_rsp.grant_addr = w_cur.head;
                    n_word.free = (w_cur.free == '0) ? '0 : FW'(w_cur.free - 1'b1);
                    n_rsp.class_free_blocks = n_word.free;
                end else if (w_nopage) begin
                    n_rsp.status = scba_pkg::ST_NO_PAGES;
                    n_rsp.class_free_blocks = w_cur.free;
                end else begin
                    w_cls_we     = 1'b1;
                    w_carve_take = 1'b1;
                    n_rsp.grant_addr = w_gaddr[AW-1:0];
                    n_word.cpage  = w_pg;
                    n_word.cvalid = 1'b1;
                    n_word.cidx   = IDX_W'(w_ix + 1'b1);
                    n_word.free   = (w_fadd[FW-1:0] == '0) ? '0 :
                        FW'(w_fadd[FW-1:0] - 1'b1);
                    n_rsp.class_free_blocks = n_word.free;
                end
            end
            scba_pkg::BK_POP: begin
                n_st     = scba_pkg::BK_IDLE;
                w_cls_we = 1'b1;
                n_word   = r_word;
                n_word.head   = w_link_rd[AW-1:0];
                n_word.head_v = w_link_rd[AW];
            end
            default: n_st = scba_pkg::BK_IDLE;
        endcase
        w_cls_wdata = n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= scba_pkg::BK_IDLE;
            r_ovalid    <= 1'b0;
            r_next_page <= '0;
            r_cls_ok    <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == scba_pkg::BK_IDLE && i_cmd_valid && o_cmd_ready) r_cmd <= i_cmd;
            if (r_st == scba_pkg::BK_READ) begin
                r_rsp  <= n_rsp;
                r_word <= n_word;
            end
            if (w_carve_take && w_carve_new) r_next_page <= PG_W'(r_next_page + 1'b1);
            if (w_cls_we) r_cls_ok[w_c] <= 1'b1;
            if ((r_st == scba_pkg::BK_READ && n_st == scba_pkg::BK_IDLE) ||
                r_st == scba_pkg::BK_POP)
                r_ovalid <= 1'b1;
            else if (r_ovalid && i_rsp_ready)
                r_ovalid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== src/size_class_block_allocator.sv =====
// Size-class block allocator top: front classifier, 2-entry command queue, back end.
// The back end takes one request at a time and reads its class word; a free-list pop
// also waits on the link memory read. The back end takes no new request while a result
// is held on the output and not yet accepted.
// Reset: synchronous active low; all lists empty, no pages claimed.
// Depends on scba_pkg, scba_front, scba_back, scba_ram.
`default_nettype none
module size_class_block_allocator #(
    parameter int unsigned NUM_PAGES       = 64,
    parameter int unsigned PAGE_BYTES      = 8192,
    parameter int unsigned NUM_CLASSES     = 47,
    parameter int unsigned HEADER_BYTES    = 8,
    parameter int unsigned ALIGN_BYTES     = 4,
    parameter int unsigned MIN_BLOCK_BYTES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [55:0]  s_axis_tdata,  // req_size[31:0], block_addr[50:32], zero pad
    input  wire [0:0]   s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // grant_addr[18:0], size_class[24:19],
                                       // class_free_blocks[41:25], zero pad
    output logic [1:0]  m_axis_tuser   // status
);
    logic cmd_valid, cmd_ready;
    scba_pkg::t_cmd cmd;
    scba_pkg::t_rsp rsp;

    scba_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tuser), .i_size(s_axis_tdata[31:0]),
        .i_addr(s_axis_tdata[50:32]),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    scba_back #(
        .NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES), .NUM_CLASSES(NUM_CLASSES),
        .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES),
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready), .o_rsp(rsp)
    );

    assign m_axis_tdata = {6'd0, rsp.class_free_blocks, rsp.size_class, rsp.grant_addr};
    assign m_axis_tuser = rsp.status;

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && rsp.status != scba_pkg::ST_DONE |-> rsp.grant_addr == '0)
        else $error("grant on failed request");
    a_oversize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && rsp.status == scba_pkg::ST_OVERSIZE |-> rsp.size_class == '0)
        else $error("oversize with class");
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> rsp.size_class < 6'(NUM_CLASSES))
        else $error("class out of range");
endmodule
`default_nettype wire
